>>> design/ice_detector_test_sequencer_assert.svh
// Assertion macros shared by the ice detector test sequencer RTL.
// Depends on nothing; expects i_clk and i_rst_n in the including module.
`ifndef ICE_DETECTOR_TEST_SEQUENCER_ASSERT_SVH
`define ICE_DETECTOR_TEST_SEQUENCER_ASSERT_SVH

// Clocked check, skipped while reset is held.
`define IDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define IDS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> design/ids_pkg.sv
// Shared types and constants for the ice detector test sequencer.
// No dependencies; imported by ids_channel and the top level.
`default_nettype none

package ids_pkg;

    localparam int VOLT_W  = 10;
    localparam int MACH_W  = 10;
    localparam int TICK_W  = 16;
    localparam int SEC_W   = 7;
    localparam int FAULT_W = 4;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [VOLT_W-1:0] RST_VOLTAGE_THRESHOLD   = VOLT_W'(180);
    localparam logic [MACH_W-1:0] RST_MACH_LIMIT          = MACH_W'(320);
    localparam logic [TICK_W-1:0] RST_TICKS_PER_SECOND    = TICK_W'(100);
    localparam logic [SEC_W-1:0]  RST_DRIVE_SECONDS       = SEC_W'(8);
    localparam logic [SEC_W-1:0]  RST_LIGHT_AFTER_SECONDS = SEC_W'(41);
    localparam logic [SEC_W-1:0]  RST_CYCLE_END_SECONDS   = SEC_W'(77);

    // fault_flags bit positions
    localparam int FLT_LEFT_FAULT   = 0;
    localparam int FLT_RIGHT_FAULT  = 1;
    localparam int FLT_LEFT_FALSE   = 2;
    localparam int FLT_RIGHT_FALSE  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLTAGE_THRESHOLD   = 3'd0,
        REG_MACH_LIMIT          = 3'd1,
        REG_TICKS_PER_SECOND    = 3'd2,
        REG_DRIVE_SECONDS       = 3'd3,
        REG_LIGHT_AFTER_SECONDS = 3'd4,
        REG_CYCLE_END_SECONDS   = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_threshold;
        logic [MACH_W-1:0] mach_limit;
        logic [TICK_W-1:0] ticks_per_second;
        logic [SEC_W-1:0]  drive_seconds;
        logic [SEC_W-1:0]  light_after_seconds;
        logic [SEC_W-1:0]  cycle_end_seconds;
    } t_cfg;

    typedef struct packed {
        logic              test_running;
        logic              drive_flag;
        logic              light_flag;
        logic [TICK_W-1:0] tick_count;
        logic [SEC_W-1:0]  seconds;
    } t_chan_state;

    // Input beat, last field in the lowest bits.
    typedef struct packed {
        logic [5:0]         pad;
        logic [FAULT_W-1:0] fault_flags;
        logic               icing_present;
        logic [MACH_W-1:0]  mach_number;
        logic               test_switch;
        logic               right_power_on;
        logic               left_power_on;
        logic [VOLT_W-1:0]  right_ac_voltage;
        logic [VOLT_W-1:0]  right_dc_voltage;
        logic [VOLT_W-1:0]  left_ac_voltage;
        logic [VOLT_W-1:0]  left_dc_voltage;
    } t_in_beat;

    // Result beat, last field in the lowest bit.
    typedef struct packed {
        logic pad;
        logic right_test_light;
        logic left_test_light;
        logic right_test_drive;
        logic left_test_drive;
        logic right_detect;
        logic left_detect;
        logic icing_alarm;
    } t_out_beat;

endpackage

`default_nettype wire

>>> design/ice_detector_test_sequencer.sv
// Top level of the two-channel ice detector test sequencer.
// Depends on ids_pkg, ids_channel and ice_detector_test_sequencer_assert.svh.
`default_nettype none

`include "ice_detector_test_sequencer_assert.svh"

// Two-channel ice detector with self-test sequencer. Each input beat is one
// system timer tick carrying both channels' supply voltages, power switches,
// the shared test switch, Mach number, icing signal and fault flags; each
// produces exactly one result beat with the alarm, the per-channel detect
// bits and the test drive and light flags after that tick's update. A beat
// sits in the input register, where readiness, detection and the self-test
// update are worked out, and the result lands in the output register once
// that register is empty or being drained; a new beat is taken every cycle
// while the result side keeps up. Back pressure on the result side fills
// the input register and then drops s_axis_tready. Detection uses the drive
// flag held before the tick; the tick counter of a channel that is not
// ready is left alone. Configuration writes take effect on the next edge
// and belong only to idle periods; indexes 6 and 7 are ignored. Reset is
// synchronous, active low, and loads the documented register defaults.
module ice_detector_test_sequencer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [ids_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ids_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // [9:0] left_dc_voltage, [19:10] left_ac_voltage, [29:20] right_dc_voltage,
    // [39:30] right_ac_voltage, [40] left_power_on, [41] right_power_on,
    // [42] test_switch, [52:43] mach_number, [53] icing_present,
    // [57:54] fault_flags, [63:58] zero
    input  wire logic [ids_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // result stream
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] icing_alarm, [1] left_detect, [2] right_detect, [3] left_test_drive,
    // [4] right_test_drive, [5] left_test_light, [6] right_test_light, [7] zero
    output      logic [ids_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import ids_pkg::*;

    t_cfg        r_cfg;
    t_in_beat    r_in;
    logic        r_in_valid;
    t_out_beat   r_out;
    t_out_beat   n_out;
    logic        r_out_valid;
    logic        advance;
    logic        in_take;
    logic        mach_ok;
    logic        left_ready;
    logic        right_ready;
    t_chan_state left_state;
    t_chan_state left_next;
    t_chan_state right_state;
    t_chan_state right_next;

    // ---- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.voltage_threshold   <= RST_VOLTAGE_THRESHOLD;
            r_cfg.mach_limit          <= RST_MACH_LIMIT;
            r_cfg.ticks_per_second    <= RST_TICKS_PER_SECOND;
            r_cfg.drive_seconds       <= RST_DRIVE_SECONDS;
            r_cfg.light_after_seconds <= RST_LIGHT_AFTER_SECONDS;
            r_cfg.cycle_end_seconds   <= RST_CYCLE_END_SECONDS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                REG_VOLTAGE_THRESHOLD:   r_cfg.voltage_threshold   <= i_cfg_data[VOLT_W-1:0];
                REG_MACH_LIMIT:          r_cfg.mach_limit          <= i_cfg_data[MACH_W-1:0];
                REG_TICKS_PER_SECOND:    r_cfg.ticks_per_second    <= i_cfg_data[TICK_W-1:0];
                REG_DRIVE_SECONDS:       r_cfg.drive_seconds       <= i_cfg_data[SEC_W-1:0];
                REG_LIGHT_AFTER_SECONDS: r_cfg.light_after_seconds <= i_cfg_data[SEC_W-1:0];
                REG_CYCLE_END_SECONDS:   r_cfg.cycle_end_seconds   <= i_cfg_data[SEC_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ---- handshake
    // Advance the held beat whenever the result register is empty or being
    // drained; take a new beat whenever the input register frees up.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= t_in_beat'(s_axis_tdata);
        end
    end

    // ---- readiness and detection
    assign mach_ok     = r_in.mach_number < r_cfg.mach_limit;
    assign left_ready  = r_in.left_power_on && mach_ok &&
                         (r_in.left_dc_voltage >= r_cfg.voltage_threshold) &&
                         (r_in.left_ac_voltage >= r_cfg.voltage_threshold) &&
                         !r_in.fault_flags[FLT_LEFT_FAULT];
    assign right_ready = r_in.right_power_on && mach_ok &&
                         (r_in.right_dc_voltage >= r_cfg.voltage_threshold) &&
                         (r_in.right_ac_voltage >= r_cfg.voltage_threshold) &&
                         !r_in.fault_flags[FLT_RIGHT_FAULT];

    ids_channel u_left (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_ready       (left_ready),
        .i_test_switch (r_in.test_switch),
        .i_cfg         (r_cfg),
        .o_state       (left_state),
        .o_next        (left_next)
    );

    ids_channel u_right (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_ready       (right_ready),
        .i_test_switch (r_in.test_switch),
        .i_cfg         (r_cfg),
        .o_state       (right_state),
        .o_next        (right_next)
    );

    always_comb begin
        n_out                  = '0;
        // detect on the drive flag held from the previous tick
        n_out.left_detect      = left_ready &&
                                 (r_in.icing_present || left_state.drive_flag ||
                                  r_in.fault_flags[FLT_LEFT_FALSE]);
        n_out.right_detect     = right_ready &&
                                 (r_in.icing_present || right_state.drive_flag ||
                                  r_in.fault_flags[FLT_RIGHT_FALSE]);
        n_out.icing_alarm      = n_out.left_detect || n_out.right_detect;
        n_out.left_test_drive  = left_next.drive_flag;
        n_out.right_test_drive = right_next.drive_flag;
        n_out.left_test_light  = left_next.light_flag;
        n_out.right_test_light = right_next.light_flag;
    end

    // ---- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

    `IDS_ASSERT(a_full_backpressure,
        r_in_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready,
        "input accepted while both stages are full and stalled")
    `IDS_ASSERT(a_advance_fills_output,
        advance |=> m_axis_tvalid && (m_axis_tdata == $past(OUT_TDATA_W'(n_out))),
        "advanced beat did not land in the result register")
    `IDS_ASSERT(a_alarm_matches_detect,
        m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[1] || m_axis_tdata[2]),
        "icing alarm disagrees with channel detect bits")
    `IDS_ASSERT_ALWAYS(a_reset_empties,
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready,
        "pipeline not empty after reset")

endmodule

`default_nettype wire

>>> design/ids_channel.sv
// One detector channel: self-test state and its per-beat update.
// Depends on ids_pkg and ice_detector_test_sequencer_assert.svh.
`default_nettype none

`include "ice_detector_test_sequencer_assert.svh"

module ids_channel (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_advance,
    input  wire logic                 i_ready,
    input  wire logic                 i_test_switch,
    input  wire ids_pkg::t_cfg        i_cfg,
    output      ids_pkg::t_chan_state o_state,
    output      ids_pkg::t_chan_state o_next
);
    import ids_pkg::*;

    t_chan_state r_state;
    t_chan_state n_state;

    always_comb begin
        logic [TICK_W-1:0] tick_inc;
        logic [SEC_W-1:0]  sec;
        n_state  = r_state;
        tick_inc = r_state.tick_count + TICK_W'(1);
        sec      = r_state.seconds;
        if (!i_ready) begin
            // drop the test, keep the tick count
            n_state.test_running = 1'b0;
            n_state.drive_flag   = 1'b0;
            n_state.light_flag   = 1'b0;
            n_state.seconds      = '0;
        end else begin
            if (i_test_switch && (r_state.seconds == '0)) begin
                n_state.test_running = 1'b1;
            end
            if (n_state.test_running) begin
                n_state.tick_count = tick_inc;
                if (tick_inc > i_cfg.ticks_per_second) begin
                    sec                = r_state.seconds + SEC_W'(1);
                    n_state.tick_count = '0;
                end
                n_state.seconds    = sec;
                n_state.drive_flag = (sec < i_cfg.drive_seconds);
                if ((sec > i_cfg.light_after_seconds) && (sec < i_cfg.cycle_end_seconds)) begin
                    n_state.drive_flag = 1'b0;
                    n_state.light_flag = 1'b1;
                end
                if (sec >= i_cfg.cycle_end_seconds) begin
                    n_state.light_flag   = 1'b0;
                    n_state.test_running = 1'b0;
                    n_state.seconds      = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
    assign o_next  = n_state;

    `IDS_ASSERT(a_not_ready_clears,
        i_advance && !i_ready |=> !r_state.test_running && !r_state.drive_flag &&
        !r_state.light_flag && (r_state.seconds == '0),
        "channel not ready but test state survived")
    `IDS_ASSERT(a_not_ready_keeps_ticks,
        i_advance && !i_ready |=> r_state.tick_count == $past(r_state.tick_count),
        "tick count changed on a channel that is not ready")
    `IDS_ASSERT(a_idle_test_holds,
        i_advance && i_ready && !r_state.test_running &&
        !(i_test_switch && (r_state.seconds == '0)) |=> $stable(r_state),
        "idle channel state moved without a test start")

endmodule

`default_nettype wire

>>> tb/ice_detector_test_sequencer_tb.sv
// Self-checking testbench for the two-channel ice detector test sequencer.
// Depends on ids_pkg and the ice_detector_test_sequencer RTL; reads no files.
// A cycle-free predictor tracks both self-test channels and checks every result beat.

module ice_detector_test_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ids_pkg::*;

    // Receiver hold-off used to back the block up until it drops s_axis_tready.
    localparam int LONG_HOLD   = 150;
    // Watchdog: cycles without any beat on either side before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    // Cap on printed mismatch lines; every mismatch is still counted.
    localparam int PRINT_CAP   = 50;

    // Per-channel self-test state as the predictor keeps it.
    typedef struct packed {
        logic              running;
        logic              drive;
        logic              light;
        logic [TICK_W-1:0] ticks;
        logic [SEC_W-1:0]  secs;
    } t_channel;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                  i_cfg_we    = 1'b0;
    t_cfg_index            i_cfg_index = REG_VOLTAGE_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic     s_axis_tvalid = 1'b0;
    logic     s_axis_tready;
    // fields from bit 0 up: left_dc_voltage, left_ac_voltage, right_dc_voltage,
    // right_ac_voltage, left_power_on, right_power_on, test_switch, mach_number,
    // icing_present, fault_flags, zero fill
    t_in_beat s_axis_tdata  = '0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // fields from bit 0 up: icing_alarm, left_detect, right_detect, left_test_drive,
    // right_test_drive, left_test_light, right_test_light, zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the configuration registers, loaded with the reset values.
    logic [VOLT_W-1:0] cfg_volt_min      = RST_VOLTAGE_THRESHOLD;
    logic [MACH_W-1:0] cfg_mach_max      = RST_MACH_LIMIT;
    logic [TICK_W-1:0] cfg_ticks_per_sec = RST_TICKS_PER_SECOND;
    logic [SEC_W-1:0]  cfg_drive_secs    = RST_DRIVE_SECONDS;
    logic [SEC_W-1:0]  cfg_light_after   = RST_LIGHT_AFTER_SECONDS;
    logic [SEC_W-1:0]  cfg_cycle_end     = RST_CYCLE_END_SECONDS;

    t_channel left_chan  = '0;
    t_channel right_chan = '0;

    t_in_beat  pending_ticks[$];
    t_out_beat predicted_outputs[$];

    string out_field_names [8] = '{"icing_alarm", "left_detect", "right_detect",
                                   "left_test_drive", "right_test_drive",
                                   "left_test_light", "right_test_light", "pad"};

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Knobs set by the sequencing block, read by the driver and the monitor.
    bit tx_idle     = 1'b1;
    bit rx_idle     = 1'b1;
    bit rx_hold_req = 1'b0;
    bit rx_hold_ack = 1'b0;

    int tx_gap    = 0;
    int rx_wait   = 0;
    int hold_left = 0;

    ice_detector_test_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One tick of a channel's self-test sequencer. A channel that drops out of
    // readiness loses its test, but its tick counter is left where it was.
    function automatic t_channel advance_self_test(t_channel c, logic ready, logic press);
        if (!ready) begin
            c.running = 1'b0;
            c.drive   = 1'b0;
            c.light   = 1'b0;
            c.secs    = '0;
        end else begin
            // a press only starts a test from second zero
            if (press && c.secs == '0)
                c.running = 1'b1;
            // idle but ready: drive and light hold whatever they last were
            if (c.running) begin
                c.ticks = c.ticks + 16'd1;
                if (c.ticks > cfg_ticks_per_sec) begin
                    c.secs  = c.secs + 7'd1;
                    c.ticks = '0;
                end
                c.drive = (c.secs < cfg_drive_secs);
                if (c.secs > cfg_light_after && c.secs < cfg_cycle_end) begin
                    c.drive = 1'b0;
                    c.light = 1'b1;
                end
                if (c.secs >= cfg_cycle_end) begin
                    c.light   = 1'b0;
                    c.running = 1'b0;
                    c.secs    = '0;
                end
            end
        end
        return c;
    endfunction

    // Indications for one accepted tick; advances both channels.
    function automatic t_out_beat compute_detector_outputs(t_in_beat b);
        t_out_beat o;
        logic      mach_ok;
        logic      l_ready;
        logic      r_ready;
        mach_ok = (b.mach_number < cfg_mach_max);
        l_ready = b.left_power_on && mach_ok &&
                  b.left_dc_voltage >= cfg_volt_min && b.left_ac_voltage >= cfg_volt_min &&
                  !b.fault_flags[FLT_LEFT_FAULT];
        r_ready = b.right_power_on && mach_ok &&
                  b.right_dc_voltage >= cfg_volt_min && b.right_ac_voltage >= cfg_volt_min &&
                  !b.fault_flags[FLT_RIGHT_FAULT];
        o = '0;
        // detection sees the drive flag from before this tick's update
        o.left_detect  = l_ready && (b.icing_present || left_chan.drive ||
                                     b.fault_flags[FLT_LEFT_FALSE]);
        o.right_detect = r_ready && (b.icing_present || right_chan.drive ||
                                     b.fault_flags[FLT_RIGHT_FALSE]);
        o.icing_alarm  = o.left_detect || o.right_detect;
        left_chan  = advance_self_test(left_chan, l_ready, b.test_switch);
        right_chan = advance_self_test(right_chan, r_ready, b.test_switch);
        o.left_test_drive  = left_chan.drive;
        o.right_test_drive = right_chan.drive;
        o.left_test_light  = left_chan.light;
        o.right_test_light = right_chan.light;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Healthy tick under the reset thresholds: both channels ready, nothing else.
    function automatic t_in_beat nominal_tick();
        t_in_beat b;
        b = '0;
        b.left_dc_voltage  = VOLT_W'(200);
        b.left_ac_voltage  = VOLT_W'(200);
        b.right_dc_voltage = VOLT_W'(200);
        b.right_ac_voltage = VOLT_W'(200);
        b.left_power_on    = 1'b1;
        b.right_power_on   = 1'b1;
        b.mach_number      = MACH_W'(100);
        return b;
    endfunction

    // Supply voltage that mostly clears the threshold, sometimes sits on it or just under.
    function automatic logic [VOLT_W-1:0] pick_supply();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return cfg_volt_min;
        if (roll == 1 && cfg_volt_min != '0)
            return cfg_volt_min - 1'b1;
        return VOLT_W'($urandom_range(1023, cfg_volt_min));
    endfunction

    // Random tick: mostly one that keeps channels ready so tests run deep,
    // the rest raw noise over every bit of every field.
    function automatic t_in_beat make_tick(int well_pct, bit clean);
        t_in_beat    b;
        int unsigned roll;
        b = '0;
        if (clean) begin
            // always ready, switch held: the channel counts on every tick
            b.left_dc_voltage  = '1;
            b.left_ac_voltage  = '1;
            b.right_dc_voltage = '1;
            b.right_ac_voltage = '1;
            b.left_power_on    = 1'b1;
            b.right_power_on   = 1'b1;
            b.test_switch      = 1'b1;
            return b;
        end
        if ($urandom_range(99) >= well_pct) begin
            b     = t_in_beat'({$urandom, $urandom});
            b.pad = '0;
            return b;
        end
        b.left_dc_voltage  = pick_supply();
        b.left_ac_voltage  = pick_supply();
        b.right_dc_voltage = pick_supply();
        b.right_ac_voltage = pick_supply();
        b.left_power_on    = ($urandom_range(19) != 0);
        b.right_power_on   = ($urandom_range(19) != 0);
        b.test_switch      = ($urandom_range(3) == 0);
        b.icing_present    = ($urandom_range(4) == 0);
        b.mach_number      = (cfg_mach_max == '0) ? '0
                                                  : MACH_W'($urandom_range(cfg_mach_max - 1'b1));
        roll = $urandom_range(9);
        if (roll < 7)
            b.fault_flags = '0;
        else if (roll < 9)
            b.fault_flags = FAULT_W'($urandom_range(3) << 2);  // false triggers only
        else
            b.fault_flags = FAULT_W'($urandom_range(15));
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic compare_indications(t_out_beat got);
        t_out_beat want;
        if (predicted_outputs.size() == 0) begin
            report_mismatch($sformatf("result beat 0x%02h with nothing predicted", got));
            return;
        end
        want = predicted_outputs.pop_front();
        for (int i = 0; i < 8; i++) begin
            if (got[i] !== want[i])
                report_mismatch($sformatf("%s got %b want %b", out_field_names[i],
                                          got[i], want[i]));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer pending ticks, predict at the accepting edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predicted_outputs.push_back(compute_detector_outputs(s_axis_tdata));
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the beat until the block takes it
            end else if (tx_gap != 0) begin
                tx_gap        <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                s_axis_tdata  <= pending_ticks.pop_front();
                s_axis_tvalid <= 1'b1;
                // gap that follows this beat once it is taken
                tx_gap        <= tx_idle ? int'($urandom_range(15)) : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every taken result, pace m_axis_tready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        int unsigned stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
            hold_left     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                compare_indications(t_out_beat'(m_axis_tdata));
            if (rx_hold_req != rx_hold_ack) begin
                // long hold-off: let the block fill and push back on its input
                rx_hold_ack   <= rx_hold_req;
                hold_left     <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= (hold_left == 1);
            end else if (m_axis_tvalid && m_axis_tready) begin
                stall         = rx_idle ? $urandom_range(15) : 0;
                rx_wait       <= int'(stall);
                m_axis_tready <= (stall == 0);
            end else if (rx_wait != 0) begin
                rx_wait       <= rx_wait - 1;
                m_axis_tready <= (rx_wait == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up when nothing moves on either side for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    // Drive one register write; the caller drops the enable after the last one.
    task automatic write_reg(t_cfg_index idx, int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        case (idx)
            REG_VOLTAGE_THRESHOLD:   cfg_volt_min      = VOLT_W'(value);
            REG_MACH_LIMIT:          cfg_mach_max      = MACH_W'(value);
            REG_TICKS_PER_SECOND:    cfg_ticks_per_sec = TICK_W'(value);
            REG_DRIVE_SECONDS:       cfg_drive_secs    = SEC_W'(value);
            REG_LIGHT_AFTER_SECONDS: cfg_light_after   = SEC_W'(value);
            REG_CYCLE_END_SECONDS:   cfg_cycle_end     = SEC_W'(value);
            default: ;
        endcase
    endtask

    // Block until every tick is taken and every prediction has been matched.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_ticks.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0);
    endtask

    // Reprogram all registers while idle, then stream one batch of ticks.
    task automatic run_phase(int volt_min, int mach_max, int tps, int drive_s, int light_s,
                             int end_s, int n_items, int well_pct,
                             bit tx_idle_on, bit rx_idle_on, bit hold_on, bit clean);
        // one result per tick, so a short settle covers the pipeline
        repeat (4) @(posedge i_clk);
        write_reg(REG_VOLTAGE_THRESHOLD, volt_min);
        write_reg(REG_MACH_LIMIT, mach_max);
        write_reg(REG_TICKS_PER_SECOND, tps);
        write_reg(REG_DRIVE_SECONDS, drive_s);
        write_reg(REG_LIGHT_AFTER_SECONDS, light_s);
        write_reg(REG_CYCLE_END_SECONDS, end_s);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        tx_idle = tx_idle_on;
        rx_idle = rx_idle_on;
        if (hold_on)
            rx_hold_req = !rx_hold_req;
        for (int k = 0; k < n_items; k++)
            pending_ticks.push_back(make_tick(well_pct, clean));
        // sender pauses here until the block has returned every result
        wait_drained();
    endtask

    initial begin
        t_in_beat b;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed ticks under the reset configuration.
        pending_ticks.push_back('0);
        b     = '1;
        b.pad = '0;
        pending_ticks.push_back(b);                     // every field at its top value
        b = nominal_tick();
        pending_ticks.push_back(b);                     // ready, quiet
        b.icing_present = 1'b1;
        pending_ticks.push_back(b);                     // icing on both channels
        b = nominal_tick();
        b.left_dc_voltage  = RST_VOLTAGE_THRESHOLD;     // readiness right on the edges
        b.left_ac_voltage  = RST_VOLTAGE_THRESHOLD;
        b.right_dc_voltage = RST_VOLTAGE_THRESHOLD;
        b.right_ac_voltage = RST_VOLTAGE_THRESHOLD;
        b.mach_number      = RST_MACH_LIMIT - 1'b1;
        b.icing_present    = 1'b1;
        pending_ticks.push_back(b);
        for (int k = 0; k < 4; k++) begin
            // one supply just under threshold at a time
            b = nominal_tick();
            b.icing_present = 1'b1;
            case (k)
                0: b.left_dc_voltage  = RST_VOLTAGE_THRESHOLD - 1'b1;
                1: b.left_ac_voltage  = RST_VOLTAGE_THRESHOLD - 1'b1;
                2: b.right_dc_voltage = RST_VOLTAGE_THRESHOLD - 1'b1;
                default: b.right_ac_voltage = RST_VOLTAGE_THRESHOLD - 1'b1;
            endcase
            pending_ticks.push_back(b);
        end
        b = nominal_tick();
        b.icing_present = 1'b1;
        b.mach_number   = RST_MACH_LIMIT;               // too fast: nobody ready
        pending_ticks.push_back(b);
        b = nominal_tick();
        b.icing_present = 1'b1;
        b.left_power_on = 1'b0;
        pending_ticks.push_back(b);
        b.left_power_on  = 1'b1;
        b.right_power_on = 1'b0;
        pending_ticks.push_back(b);
        b = nominal_tick();
        b.icing_present = 1'b1;
        b.fault_flags[FLT_LEFT_FAULT] = 1'b1;
        pending_ticks.push_back(b);
        b.fault_flags = '0;
        b.fault_flags[FLT_RIGHT_FAULT] = 1'b1;
        pending_ticks.push_back(b);
        b = nominal_tick();
        b.fault_flags[FLT_LEFT_FALSE] = 1'b1;           // false trigger alone detects
        pending_ticks.push_back(b);
        b.fault_flags = '0;
        b.fault_flags[FLT_RIGHT_FALSE] = 1'b1;
        pending_ticks.push_back(b);
        b.fault_flags = '1;                             // faults mask the false triggers
        pending_ticks.push_back(b);
        // self-test start, run on, drop left out, restart
        b = nominal_tick();
        b.test_switch = 1'b1;
        pending_ticks.push_back(b);
        b.test_switch = 1'b0;
        pending_ticks.push_back(b);
        pending_ticks.push_back(b);
        b.left_power_on = 1'b0;
        pending_ticks.push_back(b);
        b = nominal_tick();
        b.test_switch = 1'b1;
        pending_ticks.push_back(b);
        b.test_switch = 1'b0;
        pending_ticks.push_back(b);
        wait_drained();

        // volt, mach, tps, drive, light, end, ticks, well%, tx idle, rx idle, hold, clean
        // zero ticks per second: a second passes on every running tick
        run_phase(0,    1023, 0,     3,   4,   9,   70,    85,  1, 1, 0, 0);
        // top thresholds; drive outlives the test and is held afterwards
        run_phase(1023, 1,    1,     127, 127, 4,   50,    85,  1, 0, 0, 0);
        // longest cycle, light from the first second
        run_phase(500,  600,  2,     0,   0,   127, 60,    85,  0, 1, 0, 0);
        // zero cycle end: every running tick ends the test at once
        run_phase(180,  320,  0,     5,   2,   0,   40,    80,  1, 1, 0, 0);
        // long receiver hold-off against a sender that never idles
        run_phase(300,  700,  3,     2,   3,   6,   80,    90,  0, 1, 1, 0);
        // top ticks per second: the counter runs but seconds stay at zero
        run_phase(180,  320,  65535, 1,   0,   1,   20,    100, 0, 0, 0, 1);
        // reset-style windows at one second per tick
        run_phase(180,  320,  0,     8,   41,  77,  100,   90,  1, 0, 0, 0);
        // zero Mach limit and zero threshold: nothing is ever ready
        run_phase(0,    0,    0,     127, 0,   127, 20,    50,  1, 1, 0, 0);

        // let the pipeline settle and catch any stray result beats
        repeat (8) @(posedge i_clk);
        if (predicted_outputs.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      predicted_outputs.size()));
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
